[src/mer_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Field widths, derived datapath widths, input function codes and the walk
// phase type that the rasterizer shares with its users.
// ----------------------------------------------------------------------------
package mer_pkg;

   // Input and output field widths.
   localparam int COORD_BITS = 12;
   localparam int AXIS_BITS  = 11;
   localparam int PIX_BITS   = 14;

   // Squares of a semi-axis, gradient registers and the decision value.
   localparam int SQ_BITS   = 2 * AXIS_BITS;
   localparam int GRAD_BITS = SQ_BITS + COORD_BITS + 2;
   localparam int DEC_BITS  = 64;

   // Shared multiplier: the wide operand is sized for the square of an odd column
   // term, the narrow operand for a squared semi-axis.
   localparam int MUL_A_BITS = 2 * (COORD_BITS + 1);
   localparam int MUL_B_BITS = SQ_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Stream payload widths.
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   // Input function codes.
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   // Phase of the ellipse walk.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_R1   = 2'd1,
      PH_R2   = 2'd2
   } phase_type;

endpackage

[src/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks one quadrant of an integer ellipse with the midpoint scheme and
// emits the four mirror pixels of each plotted point. One 64-bit adder and
// one multiplier are shared by every step under a small sequencer.
// ----------------------------------------------------------------------------
// Start: squares, gradient and decision value by the shared units; no result.
// Region-1 advance: the compare step starts the pixel emitter; 4 to 6 adder steps
// run overlapped with 4 pixels, and the input is ready once both are done.
// Transition point: the compare step, then six multiplier and adder steps.
// Region-2 advance: 3 to 5 adder steps, then 4 pixel transfers.
// Reset is synchronous: walk and emitter go idle; geometry and decision read zero.
module midpoint_ellipse_rasterizer (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata from bit 0 up: center_x, center_y, semi_a, semi_b, zero fill.
   input  logic [mer_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: func.
   input  logic [0:0]                        req_tuser,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata from bit 0 up: pix_x, pix_y, zero fill.
   output logic [mer_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // rsp_tuser from bit 0 up: valid_res, done_res.
   output logic [mer_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CB = mer_pkg::COORD_BITS;
   localparam int AB = mer_pkg::AXIS_BITS;
   localparam int PB = mer_pkg::PIX_BITS;
   localparam int SB = mer_pkg::SQ_BITS;
   localparam int GB = mer_pkg::GRAD_BITS;
   localparam int DB = mer_pkg::DEC_BITS;
   localparam int MA = mer_pkg::MUL_A_BITS;
   localparam int MB = mer_pkg::MUL_B_BITS;
   localparam int XB = mer_pkg::PROD_BITS;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_ASQ,
      ST_MUL_BSQ,
      ST_MUL_GY,
      ST_INIT_D1,
      ST_INIT_D2,
      ST_CMP,
      ST_R1_GX,
      ST_R1_GY,
      ST_R1_D1,
      ST_R1_D2,
      ST_R1_D3,
      ST_MO1,
      ST_MO2,
      ST_MO3,
      ST_MO4,
      ST_MO5,
      ST_MO6,
      ST_R2_GY,
      ST_R2_GX,
      ST_R2_D0,
      ST_R2_D1,
      ST_R2_D2
   } state_type;

   // Sequencer and ellipse state.
   state_type          state_ff, state_in;
   mer_pkg::phase_type phase_ff, phase_in;
   logic [CB-1:0]      ctr_x_ff, ctr_x_in, ctr_y_ff, ctr_y_in;
   logic [CB-1:0]      off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [AB-1:0]      semi_a_ff, semi_a_in, semi_b_ff, semi_b_in;
   logic [SB-1:0]      a_sq_ff, a_sq_in, b_sq_ff, b_sq_in;
   logic [SB-2:0]      qa_ff, qa_in;
   logic [GB-1:0]      grad_x_ff, grad_x_in, grad_y_ff, grad_y_in;
   logic [DB-1:0]      dec_ff, dec_in;
   logic [XB-1:0]      prod_ff, prod_in;
   logic               neg_ff, neg_in;

   // Pixel emitter.
   logic               busy_ff, busy_in;
   logic [1:0]         beat_ff, beat_in;
   logic [CB-1:0]      emit_ox_ff, emit_ox_in, emit_oy_ff, emit_oy_in;
   logic [PB-1:0]      pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic               vld_ff, vld_in, done_ff, done_in, last_ff, last_in;

   // Shared arithmetic.
   logic [DB-1:0]      alu_a, alu_b, alu_res;
   logic               alu_sub;
   logic               mul_en;
   logic [MA-1:0]      mul_a;
   logic [MB-1:0]      mul_b;

   // Emitter start request from the sequencer.
   logic               emit_go, emit_inv, emit_fin;

   logic               req_xfer, rsp_xfer, fin_y;
   logic [SB:0]        qa_sum;
   logic [CB:0]        odd;
   logic [CB-1:0]      dm1;
   logic [1:0]         beat_next;

   // Center plus or minus an offset, wrapped to the pixel width.
   function automatic logic [PB-1:0] pix_calc(input logic [CB-1:0] c,
                                              input logic [CB-1:0] o,
                                              input logic          minus);
      logic [PB-1:0] ce, oe;
      ce = PB'(c);
      oe = PB'(o);
      return minus ? (ce - oe) : (ce + oe);
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && !busy_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = busy_ff && rsp_tready;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {(mer_pkg::RSP_DATA_BITS - 2 * PB)'(0), pix_y_ff, pix_x_ff};
   assign rsp_tuser  = {done_ff, vld_ff};
   assign rsp_tlast  = last_ff;

   // One adder for every accumulate, decrement and compare step.
   assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + DB'(alu_sub);

   assign fin_y     = (off_y_ff == '0);
   assign odd       = {off_x_ff, 1'b1};
   assign dm1       = fin_y ? CB'(1) : (off_y_ff - CB'(1));
   assign qa_sum    = (SB + 1)'(prod_ff[SB-1:0]) + (SB + 1)'(2);
   assign beat_next = beat_ff + 2'd1;

   // Sequencer: next state of the walk and the shared unit's operands.
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      ctr_x_in  = ctr_x_ff;
      ctr_y_in  = ctr_y_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      semi_a_in = semi_a_ff;
      semi_b_in = semi_b_ff;
      a_sq_in   = a_sq_ff;
      b_sq_in   = b_sq_ff;
      qa_in     = qa_ff;
      grad_x_in = grad_x_ff;
      grad_y_in = grad_y_ff;
      dec_in    = dec_ff;
      neg_in    = neg_ff;
      alu_a     = dec_ff;
      alu_b     = '0;
      alu_sub   = 1'b0;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      emit_go   = 1'b0;
      emit_inv  = 1'b0;
      emit_fin  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser[0] == mer_pkg::FUNC_START) begin
                  ctr_x_in  = req_tdata[CB-1:0];
                  ctr_y_in  = req_tdata[2*CB-1:CB];
                  semi_a_in = req_tdata[2*CB+AB-1:2*CB];
                  semi_b_in = req_tdata[2*CB+2*AB-1:2*CB+AB];
                  off_x_in  = '0;
                  off_y_in  = CB'(req_tdata[2*CB+2*AB-1:2*CB+AB]);
                  grad_x_in = '0;
                  phase_in  = mer_pkg::PH_R1;
                  state_in  = ST_MUL_ASQ;
               end else begin
                  unique case (phase_ff)
                     mer_pkg::PH_R1: state_in = ST_CMP;
                     mer_pkg::PH_R2: state_in = ST_R2_GY;
                     default: begin
                        emit_go  = 1'b1;
                        emit_inv = 1'b1;
                     end
                  endcase
               end
            end
         end
         // Start: squares, gradient and initial decision value.
         ST_MUL_ASQ: begin
            mul_en   = 1'b1;
            mul_a    = MA'(semi_a_ff);
            mul_b    = MB'(semi_a_ff);
            state_in = ST_MUL_BSQ;
         end
         ST_MUL_BSQ: begin
            a_sq_in  = prod_ff[SB-1:0];
            qa_in    = qa_sum[SB:2];
            mul_en   = 1'b1;
            mul_a    = MA'(semi_b_ff);
            mul_b    = MB'(semi_b_ff);
            state_in = ST_MUL_GY;
         end
         ST_MUL_GY: begin
            b_sq_in  = prod_ff[SB-1:0];
            mul_en   = 1'b1;
            mul_a    = MA'(a_sq_ff);
            mul_b    = MB'(semi_b_ff);
            state_in = ST_INIT_D1;
         end
         ST_INIT_D1: begin
            grad_y_in = {prod_ff[GB-2:0], 1'b0};
            alu_a     = DB'(b_sq_ff);
            alu_b     = DB'(qa_ff);
            dec_in    = alu_res;
            state_in  = ST_INIT_D2;
         end
         ST_INIT_D2: begin
            alu_b    = DB'(prod_ff);
            alu_sub  = 1'b1;
            dec_in   = alu_res;
            state_in = ST_IDLE;
         end
         // Region 1 test: grad_x below grad_y keeps stepping the column.
         ST_CMP: begin
            alu_a   = DB'(grad_x_ff);
            alu_b   = DB'(grad_y_ff);
            alu_sub = 1'b1;
            emit_go = 1'b1;
            if (alu_res[DB-1]) begin
               state_in = ST_R1_GX;
            end else begin
               emit_fin = fin_y;
               phase_in = fin_y ? mer_pkg::PH_IDLE : mer_pkg::PH_R2;
               state_in = ST_MO1;
            end
         end
         ST_R1_GX: begin
            alu_a     = DB'(grad_x_ff);
            alu_b     = DB'({b_sq_ff, 1'b0});
            grad_x_in = alu_res[GB-1:0];
            off_x_in  = off_x_ff + CB'(1);
            neg_in    = dec_ff[DB-1];
            state_in  = dec_ff[DB-1] ? ST_R1_D1 : ST_R1_GY;
         end
         ST_R1_GY: begin
            alu_a     = DB'(grad_y_ff);
            alu_b     = DB'({a_sq_ff, 1'b0});
            alu_sub   = 1'b1;
            grad_y_in = alu_res[GB-1:0];
            off_y_in  = off_y_ff - CB'(1);
            state_in  = ST_R1_D1;
         end
         ST_R1_D1: begin
            alu_b    = DB'(grad_x_ff);
            dec_in   = alu_res;
            state_in = ST_R1_D2;
         end
         ST_R1_D2: begin
            alu_b    = DB'(b_sq_ff);
            dec_in   = alu_res;
            state_in = neg_ff ? ST_IDLE : ST_R1_D3;
         end
         ST_R1_D3: begin
            alu_b    = DB'(grad_y_ff);
            alu_sub  = 1'b1;
            dec_in   = alu_res;
            state_in = ST_IDLE;
         end
         // Region 2 seed: round(b_sq*odd^2/4) + a_sq*dm1^2 - a_sq*b_sq.
         ST_MO1: begin
            mul_en   = 1'b1;
            mul_a    = MA'(odd);
            mul_b    = MB'(odd);
            state_in = ST_MO2;
         end
         ST_MO2: begin
            mul_en   = 1'b1;
            mul_a    = prod_ff[MA-1:0];
            mul_b    = b_sq_ff;
            state_in = ST_MO3;
         end
         ST_MO3: begin
            alu_a    = DB'(prod_ff);
            alu_b    = DB'(2);
            dec_in   = alu_res;
            mul_en   = 1'b1;
            mul_a    = MA'(dm1);
            mul_b    = MB'(dm1);
            state_in = ST_MO4;
         end
         ST_MO4: begin
            dec_in   = {2'b00, dec_ff[DB-1:2]};
            mul_en   = 1'b1;
            mul_a    = prod_ff[MA-1:0];
            mul_b    = a_sq_ff;
            state_in = ST_MO5;
         end
         ST_MO5: begin
            alu_b    = DB'(prod_ff);
            dec_in   = alu_res;
            mul_en   = 1'b1;
            mul_a    = MA'(a_sq_ff);
            mul_b    = b_sq_ff;
            state_in = ST_MO6;
         end
         ST_MO6: begin
            alu_b    = DB'(prod_ff);
            alu_sub  = 1'b1;
            dec_in   = alu_res;
            state_in = ST_IDLE;
         end
         // Region 2: step the row, and the column when the decision is negative.
         ST_R2_GY: begin
            alu_a     = DB'(grad_y_ff);
            alu_b     = DB'({a_sq_ff, 1'b0});
            alu_sub   = 1'b1;
            grad_y_in = alu_res[GB-1:0];
            off_y_in  = off_y_ff - CB'(1);
            neg_in    = dec_ff[DB-1];
            state_in  = dec_ff[DB-1] ? ST_R2_GX : ST_R2_D1;
         end
         ST_R2_GX: begin
            alu_a     = DB'(grad_x_ff);
            alu_b     = DB'({b_sq_ff, 1'b0});
            grad_x_in = alu_res[GB-1:0];
            off_x_in  = off_x_ff + CB'(1);
            state_in  = ST_R2_D0;
         end
         ST_R2_D0: begin
            alu_b    = DB'(grad_x_ff);
            dec_in   = alu_res;
            state_in = ST_R2_D1;
         end
         ST_R2_D1: begin
            alu_b    = DB'(grad_y_ff);
            alu_sub  = 1'b1;
            dec_in   = alu_res;
            state_in = ST_R2_D2;
         end
         ST_R2_D2: begin
            alu_b    = DB'(a_sq_ff);
            dec_in   = alu_res;
            emit_go  = 1'b1;
            emit_fin = fin_y;
            if (fin_y) begin
               phase_in = mer_pkg::PH_IDLE;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Shared multiplier, registered; the product holds when it is not used.
   assign prod_in = mul_en ? (XB'(mul_a) * XB'(mul_b)) : prod_ff;

   // Pixel emitter: four mirror pixels, or one invalid result.
   always_comb begin
      busy_in    = busy_ff;
      beat_in    = beat_ff;
      emit_ox_in = emit_ox_ff;
      emit_oy_in = emit_oy_ff;
      pix_x_in   = pix_x_ff;
      pix_y_in   = pix_y_ff;
      vld_in     = vld_ff;
      done_in    = done_ff;
      last_in    = last_ff;
      if (emit_go) begin
         busy_in    = 1'b1;
         beat_in    = 2'd0;
         emit_ox_in = off_x_ff;
         emit_oy_in = off_y_ff;
         if (emit_inv) begin
            pix_x_in = '0;
            pix_y_in = '0;
            vld_in   = 1'b0;
            done_in  = 1'b0;
            last_in  = 1'b1;
         end else begin
            pix_x_in = pix_calc(ctr_x_ff, off_x_ff, 1'b0);
            pix_y_in = pix_calc(ctr_y_ff, off_y_ff, 1'b0);
            vld_in   = 1'b1;
            done_in  = emit_fin;
            last_in  = 1'b0;
         end
      end else if (rsp_xfer) begin
         if (last_ff) begin
            busy_in = 1'b0;
         end else begin
            beat_in  = beat_next;
            pix_x_in = pix_calc(ctr_x_ff, emit_ox_ff, beat_next[1]);
            pix_y_in = pix_calc(ctr_y_ff, emit_oy_ff, beat_next[0]);
            last_in  = (beat_next == 2'd3);
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= mer_pkg::PH_IDLE;
         ctr_x_ff  <= '0;
         ctr_y_ff  <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         a_sq_ff   <= '0;
         b_sq_ff   <= '0;
         grad_x_ff <= '0;
         grad_y_ff <= '0;
         dec_ff    <= '0;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         ctr_x_ff  <= ctr_x_in;
         ctr_y_ff  <= ctr_y_in;
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         a_sq_ff   <= a_sq_in;
         b_sq_ff   <= b_sq_in;
         grad_x_ff <= grad_x_in;
         grad_y_ff <= grad_y_in;
         dec_ff    <= dec_in;
         busy_ff   <= busy_in;
      end
      semi_a_ff  <= semi_a_in;
      semi_b_ff  <= semi_b_in;
      qa_ff      <= qa_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      beat_ff    <= beat_in;
      emit_ox_ff <= emit_ox_in;
      emit_oy_ff <= emit_oy_in;
      pix_x_ff   <= pix_x_in;
      pix_y_ff   <= pix_y_in;
      vld_ff     <= vld_in;
      done_ff    <= done_in;
      last_ff    <= last_in;
   end

endmodule

[dv/tb_midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Drives start and advance transfers into the rasterizer, predicts the mirror
// pixels of every plotted point with its own integer walk, and compares each
// result transfer field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;

   // One predicted result transfer.
   typedef struct packed {
      logic [mer_pkg::PIX_BITS-1:0] pix_x;
      logic [mer_pkg::PIX_BITS-1:0] pix_y;
      logic                         valid_res;
      logic                         last;
      logic                         done_res;
   } pixel_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [mer_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic [0:0]                        req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [mer_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [mer_pkg::RSP_USER_BITS-1:0] rsp_tuser;
   logic                              rsp_tlast;

   // Pixels still owed by the rasterizer, oldest first.
   pixel_type pending_pixels[$];
   pixel_type want_pix;

   // Predicted walk state.
   logic [mer_pkg::COORD_BITS-1:0] walk_ctr_x, walk_ctr_y, walk_off_x, walk_off_y;
   logic [63:0]           walk_a_sq, walk_b_sq, walk_grad_x, walk_grad_y, walk_dec;
   mer_pkg::phase_type    walk_phase;

   // Run bookkeeping.
   int  error_count;
   int  items_sent;
   int  pixels_checked;
   int  walks_finished;
   int  walks_dropped;
   int  stall_left;
   bit  calm;

   midpoint_ellipse_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the rasterizer hangs.
   initial begin
      #10_000_000;
      $display("midpoint_ellipse_rasterizer: mismatch");
      $finish;
   end

   // Mismatch reporting: one line for each mismatch.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("ERROR %0t: %s got %0d expected %0d (result %0d)",
               $realtime, what, got, want, pixels_checked);
   endtask

   // Queue the four mirror pixels of the current point.
   function automatic void push_point(input bit is_end);
      logic [63:0] xs, ys;
      pixel_type   pix;
      int          k;
      for (k = 0; k < 4; k++) begin
         xs = (k < 2) ? 64'(walk_ctr_x) + 64'(walk_off_x)
                      : 64'(walk_ctr_x) - 64'(walk_off_x);
         ys = ((k & 1) == 0) ? 64'(walk_ctr_y) + 64'(walk_off_y)
                             : 64'(walk_ctr_y) - 64'(walk_off_y);
         pix.pix_x     = xs[mer_pkg::PIX_BITS-1:0];
         pix.pix_y     = ys[mer_pkg::PIX_BITS-1:0];
         pix.valid_res = 1'b1;
         pix.last      = (k == 3);
         pix.done_res  = is_end;
         pending_pixels.push_back(pix);
      end
   endfunction

   // Integer decision value for the first point of region 2.
   function automatic void reseed_lower_arc();
      logic [63:0] odd, dm1, half_term;
      odd       = 64'd2 * 64'(walk_off_x) + 64'd1;
      dm1       = (walk_off_y == '0) ? 64'd1 : 64'(walk_off_y) - 64'd1;
      half_term = (walk_b_sq * odd * odd + 64'd2) >> 2;
      walk_dec  = half_term + walk_a_sq * dm1 * dm1 - walk_a_sq * walk_b_sq;
   endfunction

   // Advance the predicted walk by one accepted transfer.
   function automatic void step_ellipse(input logic func,
                                        input logic [mer_pkg::COORD_BITS-1:0] cx,
                                        input logic [mer_pkg::COORD_BITS-1:0] cy,
                                        input logic [mer_pkg::AXIS_BITS-1:0] a,
                                        input logic [mer_pkg::AXIS_BITS-1:0] b);
      logic [63:0] a64, b64;
      bit          is_end;
      pixel_type   pix;
      a64 = 64'(a);
      b64 = 64'(b);
      if (func == mer_pkg::FUNC_START) begin
         if (walk_phase != mer_pkg::PH_IDLE) walks_dropped++;
         walk_ctr_x  = cx;
         walk_ctr_y  = cy;
         walk_a_sq   = a64 * a64;
         walk_b_sq   = b64 * b64;
         walk_off_x  = '0;
         walk_off_y  = mer_pkg::COORD_BITS'(b);
         walk_grad_x = '0;
         walk_grad_y = 64'd2 * walk_a_sq * b64;
         walk_dec    = walk_b_sq - walk_a_sq * b64 + ((walk_a_sq + 64'd2) >> 2);
         walk_phase  = mer_pkg::PH_R1;
         return;
      end
      case (walk_phase)
         mer_pkg::PH_R1: begin
            if (walk_grad_x < walk_grad_y) begin
               push_point(1'b0);
               walk_off_x++;
               walk_grad_x += 64'd2 * walk_b_sq;
               if (walk_dec[63]) begin
                  walk_dec += walk_grad_x + walk_b_sq;
               end else begin
                  walk_off_y--;
                  walk_grad_y -= 64'd2 * walk_a_sq;
                  walk_dec += walk_grad_x + walk_b_sq - walk_grad_y;
               end
            end else begin
               // Transition point between the two regions.
               is_end = (walk_off_y == '0);
               push_point(is_end);
               reseed_lower_arc();
               walk_phase = is_end ? mer_pkg::PH_IDLE : mer_pkg::PH_R2;
               if (is_end) walks_finished++;
            end
         end
         mer_pkg::PH_R2: begin
            walk_off_y--;
            walk_grad_y -= 64'd2 * walk_a_sq;
            if (!walk_dec[63]) begin
               walk_dec = walk_dec - walk_grad_y + walk_a_sq;
            end else begin
               walk_off_x++;
               walk_grad_x += 64'd2 * walk_b_sq;
               walk_dec = walk_dec + walk_grad_x - walk_grad_y + walk_a_sq;
            end
            is_end = (walk_off_y == '0);
            if (is_end) begin
               walk_phase = mer_pkg::PH_IDLE;
               walks_finished++;
            end
            push_point(is_end);
         end
         default: begin
            // Advance with no active ellipse gives one invalid result.
            pix = '0;
            pix.last = 1'b1;
            pending_pixels.push_back(pix);
         end
      endcase
   endfunction

   // Sender gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Send one input transfer and predict its results on acceptance.
   task automatic send_item(input logic func,
                            input logic [mer_pkg::COORD_BITS-1:0] cx,
                            input logic [mer_pkg::COORD_BITS-1:0] cy,
                            input logic [mer_pkg::AXIS_BITS-1:0] a,
                            input logic [mer_pkg::AXIS_BITS-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = mer_pkg::REQ_DATA_BITS'({b, a, cy, cx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      step_ellipse(func, cx, cy, a, b);
   endtask

   // Advance transfer with random content in the unused fields.
   task automatic send_advance();
      send_item(mer_pkg::FUNC_ADVANCE,
                mer_pkg::COORD_BITS'($urandom), mer_pkg::COORD_BITS'($urandom),
                mer_pkg::AXIS_BITS'($urandom), mer_pkg::AXIS_BITS'($urandom));
   endtask

   // Hold the sender off until every predicted pixel has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Start an ellipse and advance it to its final point.
   task automatic walk_ellipse(input logic [mer_pkg::COORD_BITS-1:0] cx,
                               input logic [mer_pkg::COORD_BITS-1:0] cy,
                               input logic [mer_pkg::AXIS_BITS-1:0] a,
                               input logic [mer_pkg::AXIS_BITS-1:0] b);
      send_item(mer_pkg::FUNC_START, cx, cy, a, b);
      while (walk_phase != mer_pkg::PH_IDLE) send_advance();
   endtask

   // Advances with nothing to walk: right after reset.
   task automatic test_idle_advance();
      send_advance();
      send_advance();
   endtask

   // Directed corners: largest axes, coordinate wrap, zero axes, restart.
   task automatic test_corner_ellipses();
      send_item(mer_pkg::FUNC_START, 12'hfff, 12'hfff, 11'h7ff, 11'h7ff);
      repeat (3) send_advance();
      // Restart while active drops the old walk; offsets go below zero.
      send_item(mer_pkg::FUNC_START, 12'h000, 12'h000, 11'h7ff, 11'h7ff);
      repeat (3) send_advance();
      // Flat ellipse: the transition point is the final one.
      walk_ellipse(12'h000, 12'hfff, 11'h7ff, 11'h000);
      send_advance();
      // Zero width gives a vertical run of points.
      walk_ellipse(12'hfff, 12'h000, 11'h000, 11'd3);
      // Both axes zero: one point, all four pixels on the center.
      walk_ellipse(12'h800, 12'h7ff, 11'h000, 11'h000);
      send_advance();
      walk_ellipse(12'h555, 12'haaa, 11'd1, 11'd1);
   endtask

   // Random traffic: mostly complete small ellipses, some dropped walks and noise.
   task automatic test_random_walks(input int item_target);
      int r;
      logic [mer_pkg::AXIS_BITS-1:0] a, b;
      while (items_sent < item_target) begin
         r = $urandom_range(0, 99);
         calm = ($urandom_range(0, 9) == 0);
         if (r < 70) begin
            if ($urandom_range(0, 4) == 0) begin
               a = mer_pkg::AXIS_BITS'($urandom_range(11, 40));
               b = mer_pkg::AXIS_BITS'($urandom_range(11, 40));
            end else begin
               a = mer_pkg::AXIS_BITS'($urandom_range(0, 10));
               b = mer_pkg::AXIS_BITS'($urandom_range(0, 10));
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
            walk_ellipse(mer_pkg::COORD_BITS'($urandom), mer_pkg::COORD_BITS'($urandom),
                         a, b);
            if ($urandom_range(0, 3) == 0) send_advance();
         end else if (r < 90) begin
            // Large random ellipse, dropped after a few points.
            send_item(mer_pkg::FUNC_START,
                      mer_pkg::COORD_BITS'($urandom), mer_pkg::COORD_BITS'($urandom),
                      mer_pkg::AXIS_BITS'($urandom), mer_pkg::AXIS_BITS'($urandom));
            repeat ($urandom_range(0, 6)) send_advance();
         end else begin
            send_advance();
         end
      end
      calm = 1'b0;
   endtask

   // Result stream backpressure: mostly ready, short stalls, a few long ones.
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_tready = 1'b1;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:64]:  rsp_tready = 1'b1;
               [65:91]: begin
                  rsp_tready = 1'b0;
                  stall_left = $urandom_range(0, 2);
               end
               default: begin
                  rsp_tready = 1'b0;
                  stall_left = $urandom_range(10, 40);
               end
            endcase
         end
      end
   end

   // Compare every result transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result, pix_x",
                            rsp_tdata[mer_pkg::PIX_BITS-1:0], 0);
         end else begin
            want_pix = pending_pixels.pop_front();
            if (rsp_tdata[mer_pkg::PIX_BITS-1:0] !== want_pix.pix_x)
               report_mismatch("pix_x", rsp_tdata[mer_pkg::PIX_BITS-1:0], want_pix.pix_x);
            if (rsp_tdata[2*mer_pkg::PIX_BITS-1:mer_pkg::PIX_BITS] !== want_pix.pix_y)
               report_mismatch("pix_y", rsp_tdata[2*mer_pkg::PIX_BITS-1:mer_pkg::PIX_BITS],
                               want_pix.pix_y);
            if (rsp_tuser[0] !== want_pix.valid_res)
               report_mismatch("valid_res", rsp_tuser[0], want_pix.valid_res);
            if (rsp_tuser[1] !== want_pix.done_res)
               report_mismatch("done_res", rsp_tuser[1], want_pix.done_res);
            if (rsp_tlast !== want_pix.last)
               report_mismatch("last", rsp_tlast, want_pix.last);
         end
         pixels_checked++;
      end
   end

   // Test sequence.
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = mer_pkg::FUNC_START;
      calm        = 1'b0;
      error_count = 0;
      items_sent  = 0;
      walk_phase  = mer_pkg::PH_IDLE;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_idle_advance();
      test_corner_ellipses();
      wait_drained();
      test_random_walks(items_sent + 350);

      // Drain, then give the block time to show any stray result.
      wait_drained();
      repeat (40) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch("pixels never delivered", 0, pending_pixels.size());

      $display("Sent %0d transfers; checked %0d pixel results.", items_sent, pixels_checked);
      $display("Walked %0d ellipses to the end and dropped %0d mid-walk.",
               walks_finished, walks_dropped);
      if (error_count == 0) begin
         $display("midpoint_ellipse_rasterizer: match");
      end else begin
         $display("midpoint_ellipse_rasterizer: mismatch");
      end
      $finish;
   end

endmodule
